FILE: rtl/core/mcmf_pkg.sv
package mcmf_pkg;

  localparam int NODE_SLOTS = 512;
  localparam int NODE_W     = $clog2(NODE_SLOTS);
  localparam int ARC_SLOTS  = 8192;
  localparam int ARC_W      = $clog2(ARC_SLOTS);
  localparam int ACNT_W     = ARC_W + 1;
  localparam int CAP_W      = 16;
  localparam int COST_W     = 16;
  localparam int ACOST_W    = COST_W + 1;
  localparam int DIST_W     = 32;
  localparam int FLOW_W     = 32;
  localparam int TCOST_W    = 48;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FLOW_W-1:0] FLOW_LIMIT = 32'h3f3f3f3f;
  localparam logic [ACNT_W-1:0] FIRST_ARC  = ACNT_W'(2);

  // arc word: target, next, extended cost
  localparam int ARCD_W  = NODE_W + ARC_W + ACOST_W;
  // node record: reached, hop count, distance
  localparam int REC_W   = 1 + NODE_W + DIST_W;
  // search frame: node, limit, pushed sum
  localparam int FRAME_W = NODE_W + 2 * FLOW_W;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'b1;

  typedef enum logic [4:0] {
    S_INIT_CLR,
    S_IDLE,
    S_ADD_RD1,
    S_ADD_WR1,
    S_ADD_RD2,
    S_ADD_WR2,
    S_PASS_CLR,
    S_PASS_SEED,
    S_SP_POP,
    S_SP_U,
    S_SP_ULD,
    S_SP_ARC,
    S_SP_V,
    S_SP_EVAL,
    S_SP_END,
    S_SP_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_DFS_INIT,
    S_DFS_TOP,
    S_DFS_A,
    S_DFS_V,
    S_DFS_EVAL,
    S_DFS_PUSH,
    S_DFS_POP,
    S_DFS_PLD,
    S_SET_RD,
    S_SET_A,
    S_SET_ARC,
    S_SET_R1,
    S_SET_ADV,
    S_DONE
  } mcmf_state_e;

  typedef struct packed {
    logic arc_full;
    logic src_is_sink;
    logic q_empty;
    logic a_zero;
    logic cur_zero;
    logic top_done;
    logic sp_upd;
    logic hop_over;
    logic dfs_ok;
    logic v_is_sink;
    logic stack_room;
    logic depth_one;
    logic pop_zero;
    logic f_zero;
    logic sum_hit;
    logic sink_reached;
    logic sweep_last;
    logic out_free;
  } mcmf_status_t;

endpackage

FILE: rtl/core/min_cost_max_flow_unit.sv
// Min-cost max-flow engine, successive shortest paths with blocking flow.
// Input channel (in_valid_i/in_ready_o): one word per command. Kind add
// stores an edge as a forward and reverse arc pair (no result). Kind
// clear empties the graph and totals (no result). Kind
// run computes flow from source to sink and returns one result word.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 source, 1 sink;
// always ready, write only while idle.
// Output channel (out_valid_o/out_ready_i): total flow, total cost and
// the dropped-edge status, held in an output register.
// Each pass of a run resets the node records and seeds the queue, pops
// the queue and scans the arcs of each popped node, copies the arc
// pointers, and then searches; the run ends when the sink is unreachable,
// a pass pushes no flow, or a negative cycle is found.
// After reset, the adjacency heads are swept before the first command
// is taken. A stalled receiver holds the result; further add and clear
// commands are taken meanwhile, a following run is taken but waits in
// its last state for the output register to free up.
module min_cost_max_flow_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mcmf_pkg::KIND_W-1:0]         in_kind_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         in_from_node_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         in_to_node_i,
  input  logic [mcmf_pkg::CAP_W-1:0]          in_capacity_i,
  input  logic signed [mcmf_pkg::COST_W-1:0]  in_edge_cost_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mcmf_pkg::FLOW_W-1:0]         out_total_flow_o,
  output logic signed [mcmf_pkg::TCOST_W-1:0] out_total_cost_o,
  output logic                                out_status_o
);
  import mcmf_pkg::*;

  mcmf_state_e  cmd;
  mcmf_status_t stat;

  mcmf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_kind_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mcmf_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .in_valid_i,
    .in_kind_i,
    .in_from_node_i,
    .in_to_node_i,
    .in_capacity_i,
    .in_edge_cost_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_ready_i,
    .out_valid_o,
    .out_total_flow_o,
    .out_total_cost_o,
    .out_status_o,
    .stat_o (stat)
  );

  assign in_ready_o  = cmd == S_IDLE;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: rtl/core/mcmf_ram.sv
module mcmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mcmf_ctrl.sv
module mcmf_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [mcmf_pkg::KIND_W-1:0]  in_kind_i,
  input  mcmf_pkg::mcmf_status_t       stat_i,
  output mcmf_pkg::mcmf_state_e        cmd_o
);
  import mcmf_pkg::*;

  mcmf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT_CLR:  if (stat_i.sweep_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_kind_i)
            KIND_ADD:   state_d = stat_i.arc_full ? S_IDLE : S_ADD_RD1;
            KIND_RUN:   state_d = stat_i.src_is_sink ? S_DONE : S_PASS_CLR;
            KIND_CLEAR: state_d = S_INIT_CLR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD1:   state_d = S_ADD_WR1;
      S_ADD_WR1:   state_d = S_ADD_RD2;
      S_ADD_RD2:   state_d = S_ADD_WR2;
      S_ADD_WR2:   state_d = S_IDLE;
      S_PASS_CLR:  if (stat_i.sweep_last) state_d = S_PASS_SEED;
      S_PASS_SEED: state_d = S_SP_POP;
      S_SP_POP:    state_d = stat_i.q_empty ? S_SP_END : S_SP_U;
      S_SP_U:      state_d = S_SP_ULD;
      S_SP_ULD:    state_d = S_SP_ARC;
      S_SP_ARC:    state_d = stat_i.a_zero ? S_SP_POP : S_SP_V;
      S_SP_V:      state_d = S_SP_EVAL;
      // a path of NODE_SLOTS hops means a negative cycle: end the run
      S_SP_EVAL:   state_d = (stat_i.sp_upd && stat_i.hop_over) ? S_DONE : S_SP_ARC;
      S_SP_END:    state_d = S_SP_CHK;
      S_SP_CHK:    state_d = stat_i.sink_reached ? S_COPY_RD : S_DONE;
      S_COPY_RD:   state_d = S_COPY_WR;
      S_COPY_WR:   state_d = stat_i.sweep_last ? S_DFS_INIT : S_COPY_RD;
      S_DFS_INIT:  state_d = S_DFS_TOP;
      S_DFS_TOP:   state_d = S_DFS_A;
      S_DFS_A:     state_d = (stat_i.cur_zero || stat_i.top_done) ? S_DFS_POP : S_DFS_V;
      S_DFS_V:     state_d = S_DFS_EVAL;
      S_DFS_EVAL: begin
        if (stat_i.dfs_ok && stat_i.v_is_sink) begin
          state_d = S_SET_RD;
        end else if (stat_i.dfs_ok && stat_i.stack_room) begin
          state_d = S_DFS_PUSH;
        end else begin
          state_d = S_DFS_TOP;
        end
      end
      S_DFS_PUSH:  state_d = S_DFS_TOP;
      S_DFS_POP: begin
        if (stat_i.depth_one) begin
          state_d = stat_i.pop_zero ? S_DONE : S_PASS_CLR;
        end else begin
          state_d = S_DFS_PLD;
        end
      end
      S_DFS_PLD:   state_d = S_SET_RD;
      S_SET_RD:    state_d = S_SET_A;
      S_SET_A:     state_d = stat_i.cur_zero ? S_DFS_TOP : S_SET_ARC;
      S_SET_ARC:   state_d = stat_i.f_zero ? S_SET_ADV : S_SET_R1;
      S_SET_R1:    state_d = stat_i.sum_hit ? S_DFS_TOP : S_SET_ADV;
      S_SET_ADV:   state_d = S_DFS_TOP;
      S_DONE:      if (stat_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  assign cmd_o = state_q;

endmodule

FILE: rtl/core/mcmf_dp.sv
module mcmf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcmf_pkg::mcmf_state_e               cmd_i,
  input  logic                                in_valid_i,
  input  logic [mcmf_pkg::KIND_W-1:0]         in_kind_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         in_from_node_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         in_to_node_i,
  input  logic [mcmf_pkg::CAP_W-1:0]          in_capacity_i,
  input  logic signed [mcmf_pkg::COST_W-1:0]  in_edge_cost_i,
  input  logic                                cfg_valid_i,
  input  logic [mcmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcmf_pkg::NODE_W-1:0]         cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mcmf_pkg::FLOW_W-1:0]         out_total_flow_o,
  output logic signed [mcmf_pkg::TCOST_W-1:0] out_total_cost_o,
  output logic                                out_status_o,
  output mcmf_pkg::mcmf_status_t              stat_o
);
  import mcmf_pkg::*;

  // item and configuration
  logic [NODE_W-1:0]         from_q, to_q, src_q, sink_q;
  logic [CAP_W-1:0]          cap_q;
  logic signed [ACOST_W-1:0] cost_q;
  // totals
  logic [ACNT_W-1:0]         arc_cnt_q;
  logic [FLOW_W-1:0]         flow_q;
  logic signed [TCOST_W-1:0] tcost_q;
  logic                      ovf_q;
  // sweep, queue
  logic [NODE_W-1:0]         cnt_q, qh_q, qt_q;
  logic [NODE_W:0]           qn_q;
  // current node and arc
  logic [NODE_W-1:0]         u_q, hops_u_q, v_q;
  logic signed [DIST_W-1:0]  dist_u_q;
  logic [ARC_W-1:0]          a_q, nxt_q;
  logic signed [ACOST_W-1:0] acost_q;
  logic [CAP_W-1:0]          res_q;
  // search
  logic [NODE_W-1:0]         top_node_q;
  logic [FLOW_W-1:0]         top_lim_q, top_sum_q, f_q;
  logic [NODE_W:0]           depth_q;
  logic signed [TCOST_W-1:0] mul_q;
  // result word
  logic                      out_valid_q, out_status_q;
  logic [FLOW_W-1:0]         out_flow_q;
  logic signed [TCOST_W-1:0] out_cost_q;

  // memory ports
  logic                  head_we, cur_we, arc_we, res_we, rec_we, onp_we, que_we, stk_we;
  logic [NODE_W-1:0]     head_wa, head_ra, cur_wa, cur_ra, rec_wa, rec_ra;
  logic [NODE_W-1:0]     onp_wa, onp_ra, que_wa, que_ra, stk_wa, stk_ra;
  logic [ARC_W-1:0]      head_wd, head_rd, cur_wd, cur_rd;
  logic [ARC_W-1:0]      arc_wa, arc_ra, res_wa, res_ra;
  logic [ARCD_W-1:0]     arc_wd, arc_rd;
  logic [CAP_W-1:0]      res_wd, res_rd;
  logic [REC_W-1:0]      rec_wd, rec_rd;
  logic                  onp_wd, onp_rd;
  logic [NODE_W-1:0]     que_wd, que_rd;
  logic [FRAME_W-1:0]    stk_wd, stk_rd;

  mcmf_ram #(.WIDTH(ARC_W), .DEPTH(NODE_SLOTS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  mcmf_ram #(.WIDTH(ARC_W), .DEPTH(NODE_SLOTS)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_wa), .wdata_i(cur_wd),
    .raddr_i(cur_ra), .rdata_o(cur_rd));
  mcmf_ram #(.WIDTH(ARCD_W), .DEPTH(ARC_SLOTS)) u_arc (
    .clk_i, .we_i(arc_we), .waddr_i(arc_wa), .wdata_i(arc_wd),
    .raddr_i(arc_ra), .rdata_o(arc_rd));
  mcmf_ram #(.WIDTH(CAP_W), .DEPTH(ARC_SLOTS)) u_res (
    .clk_i, .we_i(res_we), .waddr_i(res_wa), .wdata_i(res_wd),
    .raddr_i(res_ra), .rdata_o(res_rd));
  mcmf_ram #(.WIDTH(REC_W), .DEPTH(NODE_SLOTS)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_wa), .wdata_i(rec_wd),
    .raddr_i(rec_ra), .rdata_o(rec_rd));
  mcmf_ram #(.WIDTH(1), .DEPTH(NODE_SLOTS)) u_onp (
    .clk_i, .we_i(onp_we), .waddr_i(onp_wa), .wdata_i(onp_wd),
    .raddr_i(onp_ra), .rdata_o(onp_rd));
  mcmf_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_wa), .wdata_i(que_wd),
    .raddr_i(que_ra), .rdata_o(que_rd));
  mcmf_ram #(.WIDTH(FRAME_W), .DEPTH(NODE_SLOTS)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  // field views
  logic [NODE_W-1:0]         arc_tgt;
  logic [ARC_W-1:0]          arc_nxt;
  logic signed [ACOST_W-1:0] arc_cst;
  logic                      rec_reached;
  logic signed [DIST_W-1:0]  rec_dist;

  assign arc_tgt     = arc_rd[ARCD_W-1 -: NODE_W];
  assign arc_nxt     = arc_rd[ACOST_W +: ARC_W];
  assign arc_cst     = arc_rd[ACOST_W-1:0];
  assign rec_reached = rec_rd[REC_W-1];
  assign rec_dist    = rec_rd[DIST_W-1:0];

  // arithmetic
  logic signed [DIST_W-1:0]    cost_ext, nd;
  logic [NODE_W:0]             hop_next;
  logic                        sp_upd, sp_push, dfs_ok, in_acc;
  logic [FLOW_W-1:0]           rem, res_ext, want, sum_next;
  logic [FLOW_W:0]             fsum;
  logic [FLOW_W-1:0]           flow_sat;
  logic signed [TCOST_W:0]     tsum;
  logic signed [TCOST_W-1:0]   tcost_sat;
  logic signed [FLOW_W+ACOST_W:0] prod;
  logic [ARC_W-1:0]            a_cnt_lo;
  logic [NODE_W:0]             dep_m1, dep_m2;

  assign in_acc   = in_valid_i && (cmd_i == S_IDLE);
  assign cost_ext = {{(DIST_W-ACOST_W){acost_q[ACOST_W-1]}}, acost_q};
  assign nd       = dist_u_q + cost_ext;
  assign hop_next = {1'b0, hops_u_q} + 1'b1;
  assign sp_upd   = (res_q != '0) && (!rec_reached || (rec_dist > nd));
  assign sp_push  = sp_upd && !hop_next[NODE_W] && !onp_rd &&
                    (qn_q < (NODE_W+1)'(NODE_SLOTS));
  assign dfs_ok   = !onp_rd && rec_reached && (rec_dist == nd) && (res_q != '0);
  assign rem      = top_lim_q - top_sum_q;
  assign res_ext  = FLOW_W'(res_q);
  assign want     = (res_ext < rem) ? res_ext : rem;
  assign sum_next = top_sum_q + f_q;
  assign fsum     = {1'b0, flow_q} + {1'b0, want};
  assign flow_sat = fsum[FLOW_W] ? '1 : fsum[FLOW_W-1:0];
  assign tsum     = {tcost_q[TCOST_W-1], tcost_q} + {mul_q[TCOST_W-1], mul_q};
  assign prod     = $signed({1'b0, f_q}) * arc_cst;
  assign a_cnt_lo = arc_cnt_q[ARC_W-1:0];
  assign dep_m1   = depth_q - 1'b1;
  assign dep_m2   = depth_q - 2'd2;

  always_comb begin
    if (tsum[TCOST_W] != tsum[TCOST_W-1]) begin
      tcost_sat = tsum[TCOST_W] ? {1'b1, {(TCOST_W-1){1'b0}}}
                                : {1'b0, {(TCOST_W-1){1'b1}}};
    end else begin
      tcost_sat = tsum[TCOST_W-1:0];
    end
  end

  // memory port steering
  always_comb begin
    head_we = 1'b0; head_wa = from_q; head_wd = a_cnt_lo; head_ra = from_q;
    cur_we  = 1'b0; cur_wa  = top_node_q; cur_wd = nxt_q; cur_ra = top_node_q;
    arc_we  = 1'b0; arc_wa  = a_cnt_lo; arc_wd = {to_q, head_rd, cost_q}; arc_ra = a_q;
    res_we  = 1'b0; res_wa  = a_cnt_lo; res_wd = cap_q; res_ra = a_q;
    rec_we  = 1'b0; rec_wa  = v_q; rec_wd = '0; rec_ra = v_q;
    onp_we  = 1'b0; onp_wa  = v_q; onp_wd = 1'b0; onp_ra = arc_tgt;
    que_we  = 1'b0; que_wa  = qt_q; que_wd = v_q; que_ra = qh_q;
    stk_we  = 1'b0; stk_wa  = dep_m1[NODE_W-1:0];
    stk_wd  = {top_node_q, top_lim_q, top_sum_q};
    stk_ra  = dep_m2[NODE_W-1:0];
    unique case (cmd_i)
      S_INIT_CLR: begin
        head_we = 1'b1; head_wa = cnt_q; head_wd = '0;
      end
      S_ADD_RD1: head_ra = from_q;
      S_ADD_WR1: begin
        arc_we = 1'b1;
        res_we = 1'b1;
        head_we = 1'b1; head_wa = from_q; head_wd = a_cnt_lo;
      end
      S_ADD_RD2: head_ra = to_q;
      S_ADD_WR2: begin
        arc_we = 1'b1; arc_wa = a_cnt_lo + 1'b1; arc_wd = {from_q, head_rd, -cost_q};
        res_we = 1'b1; res_wa = a_cnt_lo + 1'b1; res_wd = '0;
        head_we = 1'b1; head_wa = to_q; head_wd = a_cnt_lo + 1'b1;
      end
      S_PASS_CLR: begin
        rec_we = 1'b1; rec_wa = cnt_q; rec_wd = '0;
        onp_we = 1'b1; onp_wa = cnt_q; onp_wd = 1'b0;
      end
      S_PASS_SEED: begin
        rec_we = 1'b1; rec_wa = src_q; rec_wd = {1'b1, {(REC_W-1){1'b0}}};
        onp_we = 1'b1; onp_wa = src_q; onp_wd = 1'b1;
        que_we = 1'b1; que_wa = '0; que_wd = src_q;
      end
      S_SP_POP: que_ra = qh_q;
      S_SP_U: begin
        onp_we = 1'b1; onp_wa = que_rd; onp_wd = 1'b0;
        rec_ra = que_rd;
        head_ra = que_rd;
      end
      S_SP_ARC: begin
        arc_ra = a_q;
        res_ra = a_q;
      end
      S_SP_V, S_DFS_V: begin
        rec_ra = arc_tgt;
        onp_ra = arc_tgt;
      end
      S_SP_EVAL: begin
        if (sp_upd) begin
          rec_we = 1'b1; rec_wa = v_q; rec_wd = {1'b1, hop_next[NODE_W-1:0], nd};
        end
        if (sp_push) begin
          onp_we = 1'b1; onp_wa = v_q; onp_wd = 1'b1;
          que_we = 1'b1; que_wa = qt_q; que_wd = v_q;
        end
      end
      S_SP_END: rec_ra = sink_q;
      S_COPY_RD: head_ra = cnt_q;
      S_COPY_WR: begin
        cur_we = 1'b1; cur_wa = cnt_q; cur_wd = head_rd;
      end
      S_DFS_INIT: begin
        onp_we = 1'b1; onp_wa = src_q; onp_wd = 1'b1;
      end
      S_DFS_TOP: begin
        cur_ra = top_node_q;
        rec_ra = top_node_q;
      end
      S_DFS_A, S_SET_A: begin
        arc_ra = cur_rd;
        res_ra = cur_rd;
      end
      S_DFS_EVAL: begin
        // skip the arc unless the search goes on along it
        if (!(dfs_ok && ((v_q == sink_q) || (depth_q < (NODE_W+1)'(NODE_SLOTS))))) begin
          cur_we = 1'b1; cur_wa = top_node_q; cur_wd = nxt_q;
        end
      end
      S_DFS_PUSH: begin
        stk_we = 1'b1;
        onp_we = 1'b1; onp_wa = v_q; onp_wd = 1'b1;
      end
      S_DFS_POP: begin
        onp_we = 1'b1; onp_wa = top_node_q; onp_wd = 1'b0;
      end
      S_SET_RD: cur_ra = top_node_q;
      S_SET_ARC: begin
        if (f_q != '0) begin
          res_we = 1'b1; res_wa = a_q; res_wd = res_rd - f_q[CAP_W-1:0];
        end
        res_ra = a_q ^ ARC_W'(1);
      end
      S_SET_R1: begin
        res_we = 1'b1; res_wa = a_q ^ ARC_W'(1); res_wd = res_rd + f_q[CAP_W-1:0];
      end
      S_SET_ADV: begin
        cur_we = 1'b1; cur_wa = top_node_q; cur_wd = nxt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_q <= '0; to_q <= '0; cap_q <= '0; cost_q <= '0;
      src_q <= '0; sink_q <= NODE_W'(1);
      arc_cnt_q <= FIRST_ARC; flow_q <= '0; tcost_q <= '0; ovf_q <= 1'b0;
      cnt_q <= '0; qh_q <= '0; qt_q <= '0; qn_q <= '0;
      u_q <= '0; hops_u_q <= '0; v_q <= '0; dist_u_q <= '0;
      a_q <= '0; nxt_q <= '0; acost_q <= '0; res_q <= '0;
      top_node_q <= '0; top_lim_q <= '0; top_sum_q <= '0; f_q <= '0;
      depth_q <= '0; mul_q <= '0;
      out_valid_q <= 1'b0; out_status_q <= 1'b0; out_flow_q <= '0; out_cost_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SOURCE: src_q <= cfg_data_i;
          CFG_SINK:   sink_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i == S_INIT_CLR || cmd_i == S_PASS_CLR || cmd_i == S_COPY_WR) begin
        cnt_q <= cnt_q + 1'b1;
      end
      unique case (cmd_i)
        S_IDLE: begin
          if (in_acc) begin
            from_q <= in_from_node_i;
            to_q   <= in_to_node_i;
            cap_q  <= in_capacity_i;
            cost_q <= {in_edge_cost_i[COST_W-1], in_edge_cost_i};
            if (in_kind_i == KIND_ADD && stat_o.arc_full) begin
              ovf_q <= 1'b1;
            end
            if (in_kind_i == KIND_CLEAR) begin
              arc_cnt_q <= FIRST_ARC;
              flow_q <= '0;
              tcost_q <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        S_ADD_WR2: arc_cnt_q <= arc_cnt_q + ACNT_W'(2);
        S_PASS_SEED: begin
          qh_q <= '0;
          qt_q <= NODE_W'(1);
          qn_q <= (NODE_W+1)'(1);
        end
        S_SP_POP: begin
          if (qn_q != '0) begin
            qh_q <= qh_q + 1'b1;
            qn_q <= qn_q - 1'b1;
          end
        end
        S_SP_U: u_q <= que_rd;
        S_SP_ULD: begin
          a_q      <= head_rd;
          dist_u_q <= rec_dist;
          hops_u_q <= rec_rd[DIST_W +: NODE_W];
        end
        S_SP_V, S_DFS_V: begin
          v_q     <= arc_tgt;
          nxt_q   <= arc_nxt;
          acost_q <= arc_cst;
          res_q   <= res_rd;
        end
        S_SP_EVAL: begin
          a_q <= nxt_q;
          // a self-loop moves the node being scanned
          if (sp_upd && v_q == u_q) begin
            dist_u_q <= nd;
            hops_u_q <= hop_next[NODE_W-1:0];
          end
          if (sp_push) begin
            qt_q <= qt_q + 1'b1;
            qn_q <= qn_q + 1'b1;
          end
        end
        S_DFS_INIT: begin
          top_node_q <= src_q;
          top_lim_q  <= FLOW_LIMIT;
          top_sum_q  <= '0;
          depth_q    <= (NODE_W+1)'(1);
        end
        S_DFS_A: begin
          a_q      <= cur_rd;
          dist_u_q <= rec_dist;
        end
        S_DFS_EVAL: begin
          f_q <= want;
          if (dfs_ok && v_q == sink_q) begin
            flow_q <= flow_sat;
          end
        end
        S_DFS_PUSH: begin
          top_node_q <= v_q;
          top_lim_q  <= f_q;
          top_sum_q  <= '0;
          depth_q    <= depth_q + 1'b1;
        end
        S_DFS_POP: begin
          f_q     <= top_sum_q;
          depth_q <= dep_m1;
        end
        S_DFS_PLD: {top_node_q, top_lim_q, top_sum_q} <= stk_rd;
        S_SET_A: a_q <= cur_rd;
        S_SET_ARC: begin
          nxt_q <= arc_nxt;
          mul_q <= prod[TCOST_W-1:0];
        end
        S_SET_R1: begin
          tcost_q   <= tcost_sat;
          top_sum_q <= sum_next;
        end
        S_DONE: begin
          if (stat_o.out_free) begin
            out_valid_q  <= 1'b1;
            out_flow_q   <= flow_q;
            out_cost_q   <= tcost_q;
            out_status_q <= ovf_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.arc_full     = arc_cnt_q > ACNT_W'(ARC_SLOTS - 2);
    stat_o.src_is_sink  = src_q == sink_q;
    stat_o.q_empty      = qn_q == '0;
    stat_o.a_zero       = a_q == '0;
    stat_o.cur_zero     = cur_rd == '0;
    stat_o.top_done     = top_sum_q == top_lim_q;
    stat_o.sp_upd       = sp_upd;
    stat_o.hop_over     = hop_next[NODE_W];
    stat_o.dfs_ok       = dfs_ok;
    stat_o.v_is_sink    = v_q == sink_q;
    stat_o.stack_room   = depth_q < (NODE_W+1)'(NODE_SLOTS);
    stat_o.depth_one    = depth_q == (NODE_W+1)'(1);
    stat_o.pop_zero     = top_sum_q == '0;
    stat_o.f_zero       = f_q == '0;
    stat_o.sum_hit      = sum_next == top_lim_q;
    stat_o.sink_reached = rec_reached;
    stat_o.sweep_last   = &cnt_q;
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_total_flow_o = out_flow_q;
  assign out_total_cost_o = out_cost_q;
  assign out_status_o     = out_status_q;

  a_arc_cnt_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arc_cnt_q[0] == 1'b0) && (arc_cnt_q >= FIRST_ARC) &&
    (arc_cnt_q <= ACNT_W'(ARC_SLOTS)))
    else $error("arc count out of range");

  a_add_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == S_ADD_WR2) |=> (arc_cnt_q == $past(arc_cnt_q) + ACNT_W'(2)))
    else $error("edge load did not advance arc count");

  a_frame_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q != '0) |-> ((top_sum_q <= top_lim_q) &&
                         (depth_q <= (NODE_W+1)'(NODE_SLOTS))))
    else $error("search frame overrun");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qn_q <= (NODE_W+1)'(NODE_SLOTS))
    else $error("node queue overrun");

endmodule
